### sv/itp_pkg.sv
`timescale 1ns / 1ps

package itp_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        K_SKIP,
        K_OPERAND,
        K_LPAREN,
        K_RPAREN,
        K_OPER
    } sym_kind_t;

    typedef struct packed {
        logic [7:0] sym;
        sym_kind_t  kind;
        logic [2:0] prio;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAIN,
        B_MAIN_WAIT,
        B_FLUSH,
        B_FLUSH_WAIT
    } back_state_t;

    typedef struct packed {
        logic  full;
        logic  valid;
        item_t head;
    } queue_status_t;

    function automatic logic [2:0] incoming_prio(input logic [7:0] c);
        logic [2:0] p;
        begin
            case (c)
                CH_PLUS, CH_MINUS:         p = 3'd1;
                CH_STAR, CH_SLASH, CH_PCT: p = 3'd2;
                CH_CARET:                  p = 3'd4;
                default:                   p = 3'd0;
            endcase
            return p;
        end
    endfunction

    function automatic logic [2:0] stack_prio(input logic [7:0] c);
        logic [2:0] p;
        begin
            case (c)
                CH_PLUS, CH_MINUS:         p = 3'd1;
                CH_STAR, CH_SLASH, CH_PCT: p = 3'd2;
                CH_CARET:                  p = 3'd3;
                default:                   p = 3'd0;
            endcase
            return p;
        end
    endfunction

endpackage

### sv/itp_front.sv
`timescale 1ns / 1ps

module itp_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] symbol
    input  logic          s_tlast,
    input  logic          q_full,
    output logic          q_push,
    output itp_pkg::item_t q_item
);
    import itp_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.sym  = s_tdata;
        q_item.last = s_tlast;
        q_item.prio = incoming_prio(s_tdata);
        case (s_tdata)
            CH_SPACE, CH_TAB, CH_NUL: q_item.kind = K_SKIP;
            CH_LPAREN:                q_item.kind = K_LPAREN;
            CH_RPAREN:                q_item.kind = K_RPAREN;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET:
                                      q_item.kind = K_OPER;
            default:                  q_item.kind = K_OPERAND;
        endcase
    end

endmodule

### sv/itp_queue.sv
`timescale 1ns / 1ps

module itp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  itp_pkg::item_t        push_item,
    input  logic                  pop,
    output itp_pkg::queue_status_t status
);
    import itp_pkg::*;

    item_t             entries_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (fill_reg == (Q_AW+1)'(Q_DEPTH));
    assign status.valid = (fill_reg != '0);
    assign status.head  = entries_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/itp_back.sv
`timescale 1ns / 1ps

module itp_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  itp_pkg::queue_status_t q_status,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] out_char
    output logic                   m_tlast,
    output logic [1:0]             m_tuser    // [1:0] status
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    top_reg;

    back_state_t   state_reg, state_next;
    item_t         item_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          failed_reg, failed_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg;
    logic          m_tlast_reg;
    logic [1:0]    m_tuser_reg;

    logic          out_free;
    logic          stack_empty;
    logic          stack_full;
    logic [1:0]    cur_stat;
    logic [AW-1:0] rd_addr;

    logic          deq;
    logic          emit;
    logic [7:0]    emit_char;
    logic          emit_last;
    logic [1:0]    emit_stat;
    logic          do_push;
    logic          do_pop;
    logic          do_clear;
    logic          do_fail;
    logic          act_again;
    logic          act_done;
    logic          act_abort;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg >= CW'(STACK_DEPTH));
    assign cur_stat    = ovf_reg ? STAT_OVERFLOW : STAT_OK;
    assign rd_addr     = AW'(count_reg - 1'b1);

    // Decide what this cycle does with the current item and the stack top.
    always_comb
    begin
        deq       = 1'b0;
        emit      = 1'b0;
        emit_char = top_reg;
        emit_last = 1'b0;
        emit_stat = cur_stat;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        do_clear  = 1'b0;
        do_fail   = 1'b0;
        act_again = 1'b0;
        act_done  = 1'b0;
        act_abort = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_status.valid)
                begin
                    deq = 1'b1;
                    if (failed_reg && q_status.head.last)
                    begin
                        do_clear = 1'b1;
                    end
                end
            end
            B_MAIN:
            begin
                case (item_reg.kind)
                    K_SKIP:
                    begin
                        act_done = 1'b1;
                    end
                    K_OPERAND:
                    begin
                        if (out_free)
                        begin
                            emit      = 1'b1;
                            emit_char = item_reg.sym;
                            act_done  = 1'b1;
                        end
                    end
                    K_LPAREN:
                    begin
                        do_push  = 1'b1;
                        act_done = 1'b1;
                    end
                    K_OPER:
                    begin
                        if (!stack_empty && (stack_prio(top_reg) >= item_reg.prio))
                        begin
                            if (out_free)
                            begin
                                emit      = 1'b1;
                                do_pop    = 1'b1;
                                act_again = 1'b1;
                            end
                        end
                        else
                        begin
                            do_push  = 1'b1;
                            act_done = 1'b1;
                        end
                    end
                    K_RPAREN:
                    begin
                        if (stack_empty)
                        begin
                            if (out_free)
                            begin
                                emit      = 1'b1;
                                emit_char = CH_NUL;
                                emit_last = 1'b1;
                                emit_stat = STAT_UNDERFLOW;
                                act_abort = 1'b1;
                                do_clear  = item_reg.last;
                                do_fail   = !item_reg.last;
                            end
                        end
                        else if (top_reg == CH_LPAREN)
                        begin
                            do_pop   = 1'b1;
                            act_done = 1'b1;
                        end
                        else if (out_free)
                        begin
                            emit      = 1'b1;
                            do_pop    = 1'b1;
                            act_again = 1'b1;
                        end
                    end
                    default:
                    begin
                        act_done = 1'b1;
                    end
                endcase
            end
            B_FLUSH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (!stack_empty)
                    begin
                        do_pop    = 1'b1;
                        act_again = 1'b1;
                    end
                    else
                    begin
                        emit_char = CH_NUL;
                        emit_last = 1'b1;
                        do_clear  = 1'b1;
                        act_done  = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_status.valid && !failed_reg)
                begin
                    state_next = B_MAIN;
                end
            end
            B_MAIN:
            begin
                if (act_again)
                begin
                    state_next = B_MAIN_WAIT;
                end
                else if (act_abort)
                begin
                    state_next = B_IDLE;
                end
                else if (act_done)
                begin
                    state_next = item_reg.last ? B_FLUSH_WAIT : B_IDLE;
                end
            end
            B_MAIN_WAIT:
            begin
                state_next = B_MAIN;
            end
            B_FLUSH:
            begin
                if (act_again)
                begin
                    state_next = B_FLUSH_WAIT;
                end
                else if (act_done)
                begin
                    state_next = B_IDLE;
                end
            end
            B_FLUSH_WAIT:
            begin
                state_next = B_FLUSH;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        failed_next   = failed_reg;
        m_tvalid_next = m_tvalid_reg;
        if (do_clear)
        begin
            count_next  = '0;
            ovf_next    = 1'b0;
            failed_next = 1'b0;
        end
        else
        begin
            if (do_fail)
            begin
                failed_next = 1'b1;
            end
            if (do_pop)
            begin
                count_next = count_reg - 1'b1;
            end
            else if (do_push)
            begin
                if (stack_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            failed_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            failed_reg   <= failed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deq)
        begin
            item_reg <= q_status.head;
        end
        if (emit)
        begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= emit_last;
            m_tuser_reg <= emit_stat;
        end
    end

    // The top is read through a register from the settled count; the wait states cover that.
    always_ff @(posedge clk)
    begin
        if (do_push && !stack_full && !do_clear)
        begin
            stack_mem[count_reg[AW-1:0]] <= item_reg.sym;
        end
        top_reg <= stack_mem[rd_addr];
    end

    assign q_pop    = deq;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sv/infix_to_postfix_converter_unit.sv
`timescale 1ns / 1ps
// An accepted character passes through the queue and the item register to the output.
// The stack engine takes one character at a time, in an idle and then a main state;
// each popped operator adds a wait state; an expression end adds flush states for the NUL.
// The stack memory read is registered, so a pop waits for the new top to be read.
// Reset (rst_n, asynchronous, active low) empties the queue and the stack and clears flags.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // end_of_expr
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // last
    output logic [1:0] m_tuser    // [1:0] status
);
    import itp_pkg::*;

    logic          q_push;
    logic          q_pop;
    item_t         q_item;
    queue_status_t q_status;

    itp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_status.full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    itp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .status    (q_status)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Every closing result of an expression is the NUL character.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == CH_NUL)
        else $error("last result is not NUL");

    // An underflow error always closes the expression.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_UNDERFLOW) |-> m_tlast)
        else $error("underflow result not marked last");

    // The front never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    // The back only takes an item when the queue holds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.valid)
        else $error("pop from empty queue");

endmodule

### tb/tb_infix_to_postfix_converter_unit.sv
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_unit;

    import itp_pkg::*;

    localparam int STACK_SLOTS = 32;
    localparam int IDLE_LIMIT  = 2000;
    localparam int ITEM_BUDGET = 220;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] st;
    } postfix_out_t;

    // Predicts the postfix stream and checks every output transfer against it.
    class postfix_scoreboard;
        logic [7:0]   op_mem [STACK_SLOTS];
        int unsigned  op_count;
        bit           overflow_flag;
        bit           in_error;
        postfix_out_t want_q[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
            clear_expression();
        endfunction

        function void clear_expression();
            op_count      = 0;
            overflow_flag = 1'b0;
            in_error      = 1'b0;
        endfunction

        function int rank_on_stack(logic [7:0] c);
            case (c)
                CH_PLUS, CH_MINUS:         return 1;
                CH_STAR, CH_SLASH, CH_PCT: return 2;
                CH_CARET:                  return 3;
                default:                   return 0;
            endcase
        endfunction

        function int rank_arriving(logic [7:0] c);
            case (c)
                CH_PLUS, CH_MINUS:         return 1;
                CH_STAR, CH_SLASH, CH_PCT: return 2;
                CH_CARET:                  return 4;
                default:                   return 0;
            endcase
        endfunction

        function logic [1:0] run_status();
            return overflow_flag ? STAT_OVERFLOW : STAT_OK;
        endfunction

        function void expect_char(logic [7:0] ch, logic last, logic [1:0] st);
            postfix_out_t r;
            r.ch   = ch;
            r.last = last;
            r.st   = st;
            want_q.push_back(r);
        endfunction

        function void push_operator(logic [7:0] c);
            // A push onto a full stack is lost and marks the expression.
            if (op_count >= STACK_SLOTS)
                overflow_flag = 1'b1;
            else
            begin
                op_mem[op_count] = c;
                op_count++;
            end
        endfunction

        function void pop_to_output();
            op_count--;
            expect_char(op_mem[op_count], 1'b0, run_status());
        endfunction

        function void note_symbol(logic [7:0] sym, logic eoe);
            bit searching;
            if (in_error)
            begin
                if (eoe)
                    clear_expression();
                return;
            end
            case (sym)
                CH_SPACE, CH_TAB, CH_NUL: ;
                CH_LPAREN: push_operator(sym);
                CH_RPAREN:
                begin
                    searching = 1'b1;
                    while (searching)
                    begin
                        if (op_count == 0)
                        begin
                            expect_char(CH_NUL, 1'b1, STAT_UNDERFLOW);
                            in_error = 1'b1;
                            if (eoe)
                                clear_expression();
                            return;
                        end
                        if (op_mem[op_count - 1] == CH_LPAREN)
                        begin
                            op_count--;
                            searching = 1'b0;
                        end
                        else
                            pop_to_output();
                    end
                end
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET:
                begin
                    while (op_count != 0 &&
                           rank_on_stack(op_mem[op_count - 1]) >= rank_arriving(sym))
                        pop_to_output();
                    push_operator(sym);
                end
                default: expect_char(sym, 1'b0, run_status());
            endcase
            if (eoe)
            begin
                while (op_count != 0)
                    pop_to_output();
                expect_char(CH_NUL, 1'b1, run_status());
                clear_expression();
            end
        endfunction

        function void check_output(logic [7:0] ch, logic last, logic [1:0] st);
            postfix_out_t want;
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected output char=%02h last=%0b status=%0d",
                             $realtime, ch, last, st);
                return;
            end
            want = want_q.pop_front();
            if (want.ch !== ch || want.last !== last || want.st !== st)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: expected char=%02h last=%0b status=%0d, ",
                              "got char=%02h last=%0b status=%0d"},
                             $realtime, want.ch, want.last, want.st, ch, last, st);
            end
        endfunction

        function int unsigned outstanding();
            return want_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    postfix_scoreboard sb;
    logic [7:0]        infix_text[$];
    int unsigned       sent_items;
    int unsigned       idle_cycles = 0;
    bit                tx_steady;
    bit                rx_steady;

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(STACK_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata, m_tlast, m_tuser);
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Output side: a random stall before each transfer, with stretches of none.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        rx_steady = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = ~rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 18);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    task automatic send_symbol(logic [7:0] sym, logic eoe);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= eoe;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_symbol(sym, eoe);
        sent_items++;
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_symbol(s[i], i == s.len() - 1);
    endtask

    // The last character of the buffered text carries the end-of-expression flag.
    task automatic send_text();
        for (int i = 0; i < infix_text.size(); i++)
            send_symbol(infix_text[i], i == infix_text.size() - 1);
        infix_text.delete();
    endtask

    function automatic void add_blank();
        if ($urandom_range(0, 7) == 0)
            infix_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 1) != 0)
            return 8'h61 + 8'($urandom_range(0, 25));
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 5))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_PCT;
            default: return CH_CARET;
        endcase
    endfunction

    function automatic void add_expression(int level);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++)
        begin
            if (t != 0)
            begin
                add_blank();
                infix_text.push_back(pick_operator());
            end
            add_blank();
            if (level < 3 && $urandom_range(0, 3) == 0)
            begin
                infix_text.push_back(CH_LPAREN);
                add_expression(level + 1);
                infix_text.push_back(CH_RPAREN);
            end
            else
                infix_text.push_back(pick_operand());
        end
    endfunction

    // Nesting deeper than the stack drops pushes; too many closings underflow.
    function automatic void add_deep_nest();
        int opens;
        int closes;
        opens  = $urandom_range(30, 36);
        closes = $urandom_range(0, 33);
        repeat (opens) infix_text.push_back(CH_LPAREN);
        infix_text.push_back(pick_operand());
        repeat (closes) infix_text.push_back(CH_RPAREN);
    endfunction

    initial
    begin
        int pick;
        sb = new();
        sent_items = 0;
        tx_steady = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Precedence, grouping and right-associative power.
        send_string("(a+b)*c^d^e");
        // Blank and tab skipped, the remaining operators, an open paren left at the end.
        send_string(" \tw/x%y-z(");
        send_symbol(CH_NUL, 1'b1);
        // A stray close paren fails the expression until its end item.
        send_symbol("a", 1'b0);
        send_symbol(CH_RPAREN, 1'b0);
        send_symbol("b", 1'b0);
        send_symbol(8'hFF, 1'b1);

        add_deep_nest();
        send_text();

        while (sent_items < ITEM_BUDGET)
        begin
            if ($urandom_range(0, 4) == 0)
                tx_steady = ~tx_steady;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                add_expression(0);
            else if (pick < 78)
                repeat ($urandom_range(1, 8)) infix_text.push_back(8'($urandom_range(0, 255)));
            else if (pick < 90)
            begin
                add_expression(0);
                infix_text.push_back(CH_RPAREN);
                if ($urandom_range(0, 1) != 0)
                    add_expression(0);
            end
            else if (pick < 95)
                add_deep_nest();
            else
            begin
                // Right-associative powers never pop, so the stack can fill up.
                repeat ($urandom_range(31, 34))
                begin
                    infix_text.push_back(pick_operand());
                    infix_text.push_back(CH_CARET);
                end
                infix_text.push_back(pick_operand());
            end
            send_text();
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
sv/itp_pkg.sv
sv/itp_front.sv
sv/itp_queue.sv
sv/itp_back.sv
sv/infix_to_postfix_converter_unit.sv
tb/tb_infix_to_postfix_converter_unit.sv
